// File: hw/rtl/sme_pkg.sv
package sme_pkg;
	localparam int MaxDim = 8;
	localparam int IdxW = 3;
	localparam int CellW = 6;
	localparam int Cells = 64;
	localparam int DimW = 4;
	localparam int DataW = 32;

	localparam logic [2:0] REQ_LOAD_A = 3'd0;
	localparam logic [2:0] REQ_LOAD_B = 3'd1;
	localparam logic [2:0] REQ_ADD = 3'd2;
	localparam logic [2:0] REQ_MUL = 3'd3;
	localparam logic [2:0] REQ_TR_A = 3'd4;
	localparam logic [2:0] REQ_TR_B = 3'd5;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_ADD = 2'd1;
	localparam logic [1:0] ERR_MUL = 2'd2;

	localparam logic [1:0] REG_ROWS_A = 2'd0;
	localparam logic [1:0] REG_COLS_A = 2'd1;
	localparam logic [1:0] REG_ROWS_B = 2'd2;
	localparam logic [1:0] REG_COLS_B = 2'd3;

	function automatic logic [DimW-1:0] dim_used(input logic [DimW-1:0] r);
		if (r == '0) return DimW'(1);
		if (r > DimW'(MaxDim)) return DimW'(MaxDim);
		return r;
	endfunction
endpackage

// File: hw/rtl/sme_ram.sv
module sme_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// File: hw/rtl/small_matrix_engine_core.sv
// channel  | dir | tdata fields (low first)                 | tuser
// s_axis   | in  | elem_row, elem_col, elem_value (38b->40)  | req_type
// m_axis   | out | out_value, out_row, out_col (38b->40)     | out_error
// apb      | in  | four 4-bit size registers at 0,4,8,12    | -
// Loads are written as they are accepted. Add and transpose step each element
// through read, settle, raise valid and transfer; multiply alternates read and
// accumulate states, one MAC per pair, through the shared 32x32 multiplier.
// After reset the two stores are cleared by a pass over all 64 cells; no
// item is accepted meanwhile. A stalled master side holds the sequencer.
module small_matrix_engine_core import sme_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [39:0] s_axis_tdata, // elem_row, elem_col, elem_value, pad
	input logic [2:0] s_axis_tuser, // req_type
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [39:0] m_axis_tdata, // out_value, out_row, out_col, pad
	output logic m_axis_tlast,
	output logic [1:0] m_axis_tuser, // out_error
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam logic [2:0] ST_CLR = 3'd0, ST_IDLE = 3'd1, ST_RD = 3'd2,
		ST_MAC = 3'd3, ST_EMIT = 3'd4, ST_OUT = 3'd5;

	logic [2:0] state_q;
	logic [DimW-1:0] ra_q, ca_q, rb_q, cb_q;
	logic [CellW-1:0] clr_q;
	logic [2:0] op_q;
	logic [IdxW-1:0] r_q, c_q, k_q;
	logic [DataW-1:0] acc_q;
	logic [DataW-1:0] res_q;
	logic [IdxW-1:0] orow_q, ocol_q;
	logic olast_q;
	logic [1:0] oerr_q;
	logic ovalid_q;

	logic [DimW-1:0] ra, ca, rb, cb, nr, nc;
	assign ra = dim_used(ra_q);
	assign ca = dim_used(ca_q);
	assign rb = dim_used(rb_q);
	assign cb = dim_used(cb_q);

	logic [2:0] req;
	logic [IdxW-1:0] er, ec;
	logic [DataW-1:0] ev;
	assign req = s_axis_tuser;
	assign er = s_axis_tdata[2:0];
	assign ec = s_axis_tdata[5:3];
	assign ev = s_axis_tdata[37:6];

	assign s_axis_tready = (state_q == ST_IDLE);
	logic acc_in;
	assign acc_in = s_axis_tvalid && s_axis_tready;

	logic we_a, we_b;
	logic [CellW-1:0] wa, ra_addr, rb_addr;
	logic [DataW-1:0] wd, da, db;
	always_comb begin
		we_a = 1'b0;
		we_b = 1'b0;
		wa = {er, ec};
		wd = ev;
		if (state_q == ST_CLR) begin
			we_a = 1'b1;
			we_b = 1'b1;
			wa = clr_q;
			wd = '0;
		end else if (acc_in) begin
			we_a = (req == REQ_LOAD_A);
			we_b = (req == REQ_LOAD_B);
		end
	end

	always_comb begin
		unique case (op_q)
			REQ_MUL: begin
				ra_addr = {r_q, k_q};
				rb_addr = {k_q, c_q};
			end
			REQ_TR_A, REQ_TR_B: begin
				ra_addr = {c_q, r_q};
				rb_addr = {c_q, r_q};
			end
			default: begin
				ra_addr = {r_q, c_q};
				rb_addr = {r_q, c_q};
			end
		endcase
	end

	sme_ram #(.Width(DataW), .Depth(Cells)) u_ram_a (.clk(clk), .we(we_a),
		.waddr(wa), .wdata(wd), .raddr(ra_addr), .rdata(da));
	sme_ram #(.Width(DataW), .Depth(Cells)) u_ram_b (.clk(clk), .we(we_b),
		.waddr(wa), .wdata(wd), .raddr(rb_addr), .rdata(db));

	logic [DataW-1:0] prod;
	assign prod = da * db;

	always_comb begin
		nr = ra;
		nc = cb;
		unique case (op_q)
			REQ_ADD: nc = ca;
			REQ_TR_A: begin
				nr = ca;
				nc = ra;
			end
			REQ_TR_B: begin
				nr = cb;
				nc = rb;
			end
			default: ;
		endcase
	end

	logic out_fire;
	assign out_fire = ovalid_q && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			ra_q <= DimW'(MaxDim);
			ca_q <= DimW'(MaxDim);
			rb_q <= DimW'(MaxDim);
			cb_q <= DimW'(MaxDim);
			ovalid_q <= 1'b0;
			op_q <= REQ_ADD;
			r_q <= '0;
			c_q <= '0;
			k_q <= '0;
		end else begin
			if (psel && penable && pwrite) begin
				if (paddr[3:2] == REG_ROWS_A) ra_q <= pwdata[3:0];
				if (paddr[3:2] == REG_COLS_A) ca_q <= pwdata[3:0];
				if (paddr[3:2] == REG_ROWS_B) rb_q <= pwdata[3:0];
				if (paddr[3:2] == REG_COLS_B) cb_q <= pwdata[3:0];
			end
			if (out_fire) ovalid_q <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CellW'(Cells - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (acc_in) begin
					op_q <= req;
					r_q <= '0;
					c_q <= '0;
					k_q <= '0;
					acc_q <= '0;
					if (req == REQ_ADD && (ra != rb || ca != cb)) begin
						res_q <= '0;
						orow_q <= '0;
						ocol_q <= '0;
						olast_q <= 1'b1;
						oerr_q <= ERR_ADD;
						state_q <= ST_OUT;
					end else if (req == REQ_MUL && ca != rb) begin
						res_q <= '0;
						orow_q <= '0;
						ocol_q <= '0;
						olast_q <= 1'b1;
						oerr_q <= ERR_MUL;
						state_q <= ST_OUT;
					end else if (req >= REQ_ADD && req <= REQ_TR_B) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: state_q <= (op_q == REQ_MUL) ? ST_MAC : ST_EMIT;
				ST_MAC: begin
					acc_q <= acc_q + prod;
					if ({1'b0, k_q} == ca - 1'b1) state_q <= ST_EMIT;
					else begin
						k_q <= k_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_EMIT: begin
					unique case (op_q)
						REQ_ADD: res_q <= da + db;
						REQ_MUL: res_q <= acc_q;
						REQ_TR_A: res_q <= da;
						default: res_q <= db;
					endcase
					orow_q <= r_q;
					ocol_q <= c_q;
					olast_q <= ({1'b0, r_q} == nr - 1'b1) && ({1'b0, c_q} == nc - 1'b1);
					oerr_q <= ERR_NONE;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!ovalid_q) begin
						ovalid_q <= 1'b1;
					end else if (out_fire) begin
						if (olast_q) state_q <= ST_IDLE;
						else begin
							k_q <= '0;
							acc_q <= '0;
							if ({1'b0, c_q} == nc - 1'b1) begin
								c_q <= '0;
								r_q <= r_q + 1'b1;
							end else c_q <= c_q + 1'b1;
							state_q <= ST_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = {2'b00, ocol_q, orow_q, res_q};
	assign m_axis_tlast = olast_q;
	assign m_axis_tuser = oerr_q;
	assign pready = 1'b1;
	always_comb begin
		unique case (paddr[3:2])
			REG_ROWS_A: prdata = {28'd0, ra_q};
			REG_COLS_A: prdata = {28'd0, ca_q};
			REG_ROWS_B: prdata = {28'd0, rb_q};
			default: prdata = {28'd0, cb_q};
		endcase
	end
endmodule

// File: hw/rtl/sme_checker.sv
module sme_checker import sme_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic m_axis_tlast,
	input logic [1:0] m_axis_tuser,
	input logic [39:0] m_axis_tdata
);
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != ERR_NONE |-> m_axis_tlast)
		else $error("error item not last");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input taken while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != ERR_NONE |-> m_axis_tdata == '0)
		else $error("error item payload not zero");
endmodule

bind small_matrix_engine_core sme_checker u_chk (.clk(clk), .arst_n(arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tlast(m_axis_tlast), .m_axis_tuser(m_axis_tuser),
	.m_axis_tdata(m_axis_tdata));
